### hdl/circular_fifo_search_remove_macros.svh
// Assertion macros for the circular FIFO with search and remove.
// Included by the top level; each macro expands to one labeled assertion.
`ifndef CIRCULAR_FIFO_SEARCH_REMOVE_MACROS_SVH
`define CIRCULAR_FIFO_SEARCH_REMOVE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CFSR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must imply a consequence in the same cycle.
`define CFSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// A condition that must imply a consequence in the next cycle.
`define CFSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cfsr_pkg.sv
// Shared types and constants for the circular FIFO with search and remove.
// Used by the sequencer and the top level; depends on nothing.
`default_nettype none

package cfsr_pkg;

    // Default storage shape.
    localparam int DEPTH_DEFAULT        = 16;
    localparam int ELEMENT_BITS_DEFAULT = 8;

    // Fixed widths of the channel fields.
    localparam int ITEM_W  = 8;
    localparam int COUNT_W = 5;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ENQ      = 2'd0,
        OP_DEQ      = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_CONTAINS = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_DEQ_DATA,
        S_SRCH,
        S_SHIFT,
        S_DONE
    } t_state;

    // Input item.
    typedef struct packed {
        t_op               operation;
        logic [ITEM_W-1:0] item;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [ITEM_W-1:0]  item_out;
        logic               done_res;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               full_res;
    } t_out_item;

endpackage

`default_nettype wire

### hdl/cfsr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package needed.
`default_nettype none

module cfsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/cfsr_ctrl.sv
// Sequencer and pointer datapath of the circular FIFO with search and remove.
// Uses cfsr_pkg; drives the slot RAM and hands each result to the top level.
`default_nettype none

module cfsr_ctrl
    import cfsr_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_item                 i_in_data,
    // Result handoff to the output register
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output t_out_item                     o_res_data,
    // Slot RAM
    output logic                          o_ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]      o_ram_wr_addr,
    output logic [ELEMENT_BITS-1:0]       o_ram_wr_data,
    output logic                          o_ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]      o_ram_rd_addr,
    input  wire logic [ELEMENT_BITS-1:0]  i_ram_rd_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EB = ELEMENT_BITS;

    localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S    = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] OFF_ONE    = CW'(1);
    localparam logic [CW-1:0] OFF_MINUS1 = CW'(DEPTH - 1);

    // Slot index of the entry at offset off from base, wrapped to the depth.
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[IW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_fill, n_fill;
    t_op             r_op, n_op;
    logic [EB-1:0]   r_key, n_key;
    logic [CW-1:0]   r_rd_k, n_rd_k;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_pend_k, n_pend_k;
    logic [ITEM_W-1:0] r_item_out, n_item_out;
    logic            r_done, n_done;
    logic            r_found, n_found;

    logic                     in_xfer;
    logic                     hit;
    logic                     walk_end;
    logic                     more;
    logic [EB+ITEM_W-1:0]     key_ext;
    logic [EB+ITEM_W-1:0]     data_ext;
    logic [CW+COUNT_W-1:0]    count_ext;

    assign in_xfer   = i_in_valid && !o_in_stall;
    // The shared comparator looks at the entry read in the previous cycle.
    assign hit       = r_pend && (i_ram_rd_data == r_key);
    assign more      = (r_rd_k < r_fill);
    assign walk_end  = !r_pend && !more;
    assign key_ext   = {{EB{1'b0}}, i_in_data.item};
    assign data_ext  = {{ITEM_W{1'b0}}, i_ram_rd_data};
    assign count_ext = {{COUNT_W{1'b0}}, r_fill};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.operation)
                        OP_ENQ:  n_state = S_ENQ;
                        OP_DEQ:  n_state = S_DEQ;
                        default: n_state = S_SRCH;
                    endcase
                end
            end
            S_ENQ:      n_state = S_DONE;
            S_DEQ:      n_state = (r_fill == '0) ? S_DONE : S_DEQ_DATA;
            S_DEQ_DATA: n_state = S_DONE;
            S_SRCH: begin
                if (hit) begin
                    n_state = (r_op == OP_REMOVE) ? S_SHIFT : S_DONE;
                end else if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake, RAM ports and the result.
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_res_valid   = (r_state == S_DONE) && i_res_ready;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_tail;
        o_ram_wr_data = r_key;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = f_slot(r_head, r_rd_k);
        case (r_state)
            S_ENQ: begin
                o_ram_wr_en = (r_fill < DEPTH_C);
            end
            S_DEQ: begin
                o_ram_rd_en   = 1'b1;
                o_ram_rd_addr = r_head;
            end
            S_SRCH: begin
                o_ram_rd_en = more;
            end
            S_SHIFT: begin
                // Move the entry read last cycle one place toward the head.
                o_ram_rd_en   = more;
                o_ram_wr_en   = r_pend;
                o_ram_wr_addr = f_slot(r_head, r_pend_k - OFF_ONE);
                o_ram_wr_data = i_ram_rd_data;
            end
            default: begin
            end
        endcase
        o_res_data.item_out  = r_item_out;
        o_res_data.done_res  = r_done;
        o_res_data.found     = r_found;
        o_res_data.count     = count_ext[COUNT_W-1:0];
        o_res_data.empty_res = (r_fill == '0);
        o_res_data.full_res  = (r_fill == DEPTH_C);
    end

    // Pointer, walk and result datapath.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_op       = r_op;
        n_key      = r_key;
        n_rd_k     = r_rd_k;
        n_pend     = r_pend;
        n_pend_k   = r_pend_k;
        n_item_out = r_item_out;
        n_done     = r_done;
        n_found    = r_found;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op       = i_in_data.operation;
                    n_key      = key_ext[EB-1:0];
                    n_item_out = '0;
                    n_done     = 1'b0;
                    n_found    = 1'b0;
                    n_rd_k     = '0;
                    n_pend     = 1'b0;
                end
            end
            S_ENQ: begin
                if (r_fill < DEPTH_C) begin
                    n_tail = f_slot(r_tail, OFF_ONE);
                    n_fill = r_fill + OFF_ONE;
                    n_done = 1'b1;
                end
            end
            S_DEQ_DATA: begin
                n_item_out = data_ext[ITEM_W-1:0];
                n_head     = f_slot(r_head, OFF_ONE);
                n_fill     = r_fill - OFF_ONE;
                n_done     = 1'b1;
            end
            S_SRCH: begin
                if (hit) begin
                    // The shift starts with the entry just after the match.
                    n_found = 1'b1;
                    n_rd_k  = r_pend_k + OFF_ONE;
                    n_pend  = 1'b0;
                end else begin
                    n_pend   = more;
                    n_pend_k = r_rd_k;
                    if (more) begin
                        n_rd_k = r_rd_k + OFF_ONE;
                    end
                end
            end
            S_SHIFT: begin
                n_pend   = more;
                n_pend_k = r_rd_k;
                if (more) begin
                    n_rd_k = r_rd_k + OFF_ONE;
                end
                if (walk_end) begin
                    n_tail = f_slot(r_tail, OFF_MINUS1);
                    n_fill = r_fill - OFF_ONE;
                    n_done = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_rd_k     <= n_rd_k;
        r_pend_k   <= n_pend_k;
        r_item_out <= n_item_out;
        r_done     <= n_done;
        r_found    <= n_found;
    end

endmodule

`default_nettype wire

### hdl/circular_fifo_search_remove.sv
// Top level of the circular FIFO with search and remove: sequencer, slot RAM
// and output register. Depends on cfsr_pkg, cfsr_ctrl, cfsr_ram and the macros.
//
// Usage: one operation (enqueue, dequeue, remove first match, contains) per
// input transfer on i_in_valid / o_in_stall; exactly one result per operation
// on o_out_valid / i_out_stall, in order.
// A contains or remove walks from the head to the first match, or over every
// stored entry on a miss; a remove that hits then closes the gap by moving
// each later entry one place toward the head. The search and the gap closing
// both step through the slot RAM one entry per cycle on its single read port,
// and a new operation is taken only once the previous one has handed its
// result on to the output register.
// o_in_stall is high while an operation is in progress; the next operation is
// taken while a finished result still waits in the output register.
// When the receiver stalls, the result holds in the output register and a
// following operation waits at its end until the register frees.
// Reset (synchronous, active low) empties the queue; slot contents are not
// cleared and no clearing pass is needed.
`default_nettype none
`include "circular_fifo_search_remove_macros.svh"

module circular_fifo_search_remove
    import cfsr_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // Input channel
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    // Output channel
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    localparam int IW = $clog2(DEPTH);

    logic                    res_valid;
    logic                    res_ready;
    t_out_item               res_data;
    logic                    ram_wr_en;
    logic [IW-1:0]           ram_wr_addr;
    logic [ELEMENT_BITS-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [IW-1:0]           ram_rd_addr;
    logic [ELEMENT_BITS-1:0] ram_rd_data;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Sequencer.
    cfsr_ctrl #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res_data    (res_data),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    // Slot storage.
    cfsr_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // The output register can take a result when empty or when it transfers now.
    assign res_ready = !r_out_valid || !i_out_stall;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A new result never overwrites one that the receiver has not taken.
    `CFSR_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, res_valid, !r_out_valid || !i_out_stall, "result overwrote a pending output")
    // An accepted operation keeps the input side stalled in the next cycle.
    `CFSR_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled while busy")
    // The empty flag agrees with the count and excludes the full flag.
    `CFSR_ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, o_out_valid && o_out_data.empty_res, o_out_data.count == '0 && !o_out_data.full_res, "empty flag disagrees with count")
    // A remove that hit cannot leave the queue full.
    `CFSR_ASSERT(a_flags_excl, i_clk, i_rst_n, !(o_out_valid && o_out_data.found && o_out_data.done_res && o_out_data.full_res), "remove hit left queue full")

endmodule

`default_nettype wire

### dv/fifo_shadow_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the circular FIFO with search and remove: a mirror of the stored entries
// that predicts each result and checks the block's results in order. Depends on cfsr_pkg.
package fifo_shadow_pkg;
    import cfsr_pkg::*;

    localparam int FIFO_DEPTH  = DEPTH_DEFAULT;
    localparam int MAX_REPORTS = 10;

    class fifo_shadow;
        // Entries held by the block, oldest first.
        logic [ITEM_W-1:0] stored[$];
        // Results still owed by the block, oldest first.
        t_out_item         expected_results[$];
        int unsigned       op_total[4];
        int unsigned       op_void[4];
        int unsigned       results_checked;
        int unsigned       mismatches;

        // Apply one operation to the mirrored entries and work out its result.
        function t_out_item apply_op(t_in_item xfer);
            t_out_item res;
            int        hit;
            res = '0;
            hit = -1;
            // The search runs from the head, so the first hit is the oldest match.
            foreach (stored[i]) begin
                if (hit < 0 && stored[i] == xfer.item) hit = i;
            end
            case (xfer.operation)
                OP_ENQ: begin
                    if (stored.size() < FIFO_DEPTH) begin
                        stored.push_back(xfer.item);
                        res.done_res = 1'b1;
                    end
                end
                OP_DEQ: begin
                    if (stored.size() > 0) begin
                        res.item_out = stored.pop_front();
                        res.done_res = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        stored.delete(hit);
                        res.done_res = 1'b1;
                        res.found    = 1'b1;
                    end
                end
                OP_CONTAINS: begin
                    res.found = (hit >= 0);
                end
                default: begin
                end
            endcase
            res.count     = COUNT_W'(stored.size());
            res.empty_res = (stored.size() == 0);
            res.full_res  = (stored.size() == FIFO_DEPTH);
            return res;
        endfunction

        // Record an accepted input transfer and queue the result it owes.
        function void note_op(t_in_item xfer);
            t_out_item res;
            res = apply_op(xfer);
            expected_results.push_back(res);
            op_total[xfer.operation]++;
            // An operation that changed nothing: dropped, empty, or missed.
            if (xfer.operation == OP_CONTAINS ? !res.found : !res.done_res)
                op_void[xfer.operation]++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("MISMATCH on result %0d, field %s: expected 0x%0h, got 0x%0h",
                             results_checked, name, want, got);
            end
        endfunction

        // Compare one accepted result transfer against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item want;
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("MISMATCH: result 0x%0h arrived with no operation outstanding",
                             got);
                return;
            end
            want = expected_results.pop_front();
            check_field("item_out", want.item_out, got.item_out);
            check_field("done_res", want.done_res, got.done_res);
            check_field("found", want.found, got.found);
            check_field("count", want.count, got.count);
            check_field("empty_res", want.empty_res, got.empty_res);
            check_field("full_res", want.full_res, got.full_res);
        endfunction

        function void report_summary();
            $display("Ran %0d enqueues (%0d dropped on full), %0d dequeues (%0d on empty),",
                     op_total[OP_ENQ], op_void[OP_ENQ], op_total[OP_DEQ], op_void[OP_DEQ]);
            $display("%0d removes (%0d missed), %0d searches (%0d missed); %0d results, %0d bad",
                     op_total[OP_REMOVE], op_void[OP_REMOVE], op_total[OP_CONTAINS],
                     op_void[OP_CONTAINS], results_checked, mismatches);
        endfunction
    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
// Regression top for circular_fifo_search_remove: directed corner cases, then random
// operation mixes with random idling on both channels. Depends on cfsr_pkg and fifo_shadow_pkg.
module tb_top;
    import cfsr_pkg::*;
    import fifo_shadow_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SEGMENTS        = 14;
    localparam int SEGMENT_OPS     = 98;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;

    // Operation mixes: push toward full, toward empty, or stay balanced.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    localparam logic [ITEM_W-1:0] FILL_VALUES [16] = '{
        8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
        8'h55, 8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;

    fifo_shadow  shadow = new;
    int unsigned cycle_cnt      = 0;
    int unsigned rx_hold_cycles = 0;
    bit          tx_eager       = 1'b0;
    bit          rx_eager       = 1'b0;

    circular_fifo_search_remove dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_cnt, shadow.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one operation after a random gap and wait for its transfer.
    // Valid is left high so a back-to-back operation never toggles it.
    task automatic send_op(input t_op op, input logic [ITEM_W-1:0] value);
        int unsigned gap;
        t_in_item    xfer;
        gap = tx_eager ? 0 : $urandom_range(0, 9);
        xfer.operation = op;
        xfer.item      = value;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= xfer;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        shadow.note_op(xfer);
    endtask

    // Stop offering and wait until every owed result has been transferred.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    // Pick an operation from the mix; searches mostly target entries that are stored.
    task automatic send_random(input t_mix mix, input bit narrow);
        int unsigned       roll;
        int unsigned       enq_lim;
        int unsigned       deq_lim;
        int unsigned       rem_lim;
        t_op               op;
        logic [ITEM_W-1:0] value;
        case (mix)
            MIX_FILL: begin
                enq_lim = 55; deq_lim = 70; rem_lim = 85;
            end
            MIX_DRAIN: begin
                enq_lim = 20; deq_lim = 55; rem_lim = 80;
            end
            default: begin
                enq_lim = 35; deq_lim = 60; rem_lim = 80;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enq_lim)
            op = OP_ENQ;
        else if (roll < deq_lim)
            op = OP_DEQ;
        else if (roll < rem_lim)
            op = OP_REMOVE;
        else
            op = OP_CONTAINS;
        if ((op == OP_REMOVE || op == OP_CONTAINS) && shadow.stored.size() > 0 &&
            $urandom_range(0, 9) < 7)
            value = shadow.stored[$urandom_range(0, shadow.stored.size() - 1)];
        else if (narrow)
            value = ITEM_W'($urandom_range(0, 7));
        else
            value = ITEM_W'($urandom_range(0, 255));
        send_op(op, value);
    endtask

    // Result side: random stalls, one long hold-off on request, check every transfer.
    initial begin : result_sink
        int unsigned hold;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                hold = rx_eager ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            shadow.check_result(o_out_data);
        end
    end

    // Stimulus: reset, directed corner cases, then random segments.
    initial begin : stimulus
        t_mix mix;
        bit   narrow;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dequeue, remove and contains on an empty queue.
        send_op(OP_DEQ, 8'hFF);
        send_op(OP_REMOVE, 8'h00);
        send_op(OP_CONTAINS, 8'hFF);

        // Fill to the brim with extreme values and duplicates.
        foreach (FILL_VALUES[i]) send_op(OP_ENQ, FILL_VALUES[i]);

        // Full queue: dropped enqueue, search reaching the last entry,
        // remove of the older of two equal entries, a miss, then a pop.
        send_op(OP_ENQ, 8'h99);
        send_op(OP_CONTAINS, 8'h60);
        send_op(OP_REMOVE, 8'h55);
        send_op(OP_REMOVE, 8'h99);
        send_op(OP_DEQ, 8'h00);
        wait_all_results();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mix      = t_mix'($urandom_range(0, 2));
            narrow   = ($urandom_range(0, 2) == 0);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            // One segment backs the block up behind a long output hold-off.
            if (seg == 2) begin
                mix            = MIX_FILL;
                tx_eager       = 1'b1;
                rx_eager       = 1'b0;
                rx_hold_cycles = HOLD_OFF_CYCLES;
            end
            for (int n = 0; n < SEGMENT_OPS; n++) send_random(mix, narrow);
            if (seg == 4 || $urandom_range(0, 2) == 0) wait_all_results();
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        shadow.report_summary();
        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/cfsr_pkg.sv
hdl/cfsr_ram.sv
hdl/cfsr_ctrl.sv
hdl/circular_fifo_search_remove.sv
dv/fifo_shadow_pkg.sv
dv/tb_top.sv
